// File: sv/fgc_pkg.sv
// ----------------------------------------------------------------------------
// fgc_pkg
// Shared widths, codes and command types of the free-space grid certifier.
// ----------------------------------------------------------------------------
package fgc_pkg;

    // field widths and fixed-point constants
    localparam int MASS_W    = 17;
    localparam int RATIO_W   = 17;
    localparam int VERDICT_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam logic [MASS_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [MASS_W-1:0] FREE_THRESHOLD_RST = 17'd32768;
    localparam logic [MASS_W-1:0] MAX_UNKNOWN_RST    = 17'd0;

    // default grid size limit
    localparam int MAX_CELLS_DEF = 65536;

    // quotient bits produced by the divider
    localparam int DIV_STEPS  = 17;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FREE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_UNKNOWN    = 2'd1;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_CERTIFIED = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_OCCUPIED  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN   = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_ERROR     = 2'd3;

    // ratio selection for the shared divider
    localparam logic [1:0] SEL_FREE    = 2'd0;
    localparam logic [1:0] SEL_UNKNOWN = 2'd1;
    localparam logic [1:0] SEL_OCC     = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       in_take;
        logic       mul_load;
        logic       cmp_load;
        logic       div_init;
        logic       div_step;
        logic       div_last;
        logic [1:0] div_sel;
        logic       out_load;
    } fgc_cmd_t;

endpackage

// File: sv/fgc_datapath.sv
// ----------------------------------------------------------------------------
// fgc_datapath
// Configuration registers, cell counters, verdict logic, shared restoring
// divider and output registers of the certifier.
// ----------------------------------------------------------------------------
module fgc_datapath #(
    parameter int MAX_CELLS = fgc_pkg::MAX_CELLS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fgc_pkg::fgc_cmd_t              cmd,
    input  logic                           cfg_valid,
    input  logic [fgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fgc_pkg::MASS_W-1:0]     cfg_data,
    input  logic [fgc_pkg::MASS_W-1:0]     free_mass,
    input  logic [fgc_pkg::MASS_W-1:0]     occ_mass,
    input  logic                           last_cell,
    output logic [fgc_pkg::VERDICT_W-1:0]  verdict,
    output logic [fgc_pkg::RATIO_W-1:0]    free_frac,
    output logic [fgc_pkg::RATIO_W-1:0]    unknown_frac,
    output logic [fgc_pkg::RATIO_W-1:0]    occupied_frac,
    output logic [fgc_pkg::RATIO_W-1:0]    cell_total
);
    import fgc_pkg::*;

    localparam int CNT_W = $clog2(MAX_CELLS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CELLS);
    localparam int PROD_W = MASS_W + CNT_W;

    // saturating increment
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        bump = (c < CNT_MAX) ? c + CNT_W'(1) : c;
    endfunction

    logic [MASS_W-1:0] thr_reg, maxr_reg;
    logic [CNT_W-1:0]  free_cnt_reg, unk_cnt_reg, occ_cnt_reg, cell_cnt_reg;
    logic              bad_reg;
    logic [CNT_W-1:0]  snap_free_reg, snap_unk_reg, snap_occ_reg, snap_cell_reg;
    logic              snap_err_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [VERDICT_W-1:0] verd_reg;
    logic [CNT_W-1:0]  div_r_reg;
    logic              div_b_reg;
    logic [RATIO_W-1:0] div_q_reg;
    logic [RATIO_W-1:0] rat_free_reg, rat_unk_reg, rat_occ_reg;
    logic [VERDICT_W-1:0] verdict_reg;
    logic [RATIO_W-1:0] free_frac_reg, unknown_frac_reg, occupied_frac_reg;
    logic [RATIO_W-1:0] cell_total_reg;

    // cell classification
    logic              cell_bad, thr_ok, ratio_ok, is_free, is_occ;
    logic [MASS_W:0]   mass_sum;
    logic [CNT_W-1:0]  free_next, unk_next, occ_next, cell_next;
    logic              bad_next;

    always_comb
    begin
        mass_sum = {1'b0, free_mass} + {1'b0, occ_mass};
        cell_bad = (free_mass > ONE_Q16) || (occ_mass > ONE_Q16) ||
                   (mass_sum > {1'b0, ONE_Q16});
        thr_ok   = (thr_reg != '0) && (thr_reg <= ONE_Q16);
        ratio_ok = (maxr_reg < ONE_Q16);
        is_free  = !cell_bad && thr_ok && (free_mass >= thr_reg) && (free_mass > occ_mass);
        is_occ   = !cell_bad && thr_ok && (occ_mass >= thr_reg) && (occ_mass > free_mass);
        bad_next  = bad_reg || cell_bad;
        cell_next = bump(cell_cnt_reg);
        free_next = is_free ? bump(free_cnt_reg) : free_cnt_reg;
        occ_next  = (!is_free && is_occ) ? bump(occ_cnt_reg) : occ_cnt_reg;
        unk_next  = (!is_free && !is_occ) ? bump(unk_cnt_reg) : unk_cnt_reg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= FREE_THRESHOLD_RST;
            maxr_reg <= MAX_UNKNOWN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FREE_THRESHOLD: thr_reg  <= cfg_data;
                REG_MAX_UNKNOWN:    maxr_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // counters, cleared when the last cell of a grid is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_cnt_reg <= '0;
            unk_cnt_reg  <= '0;
            occ_cnt_reg  <= '0;
            cell_cnt_reg <= '0;
            bad_reg      <= 1'b0;
        end
        else if (cmd.in_take)
        begin
            if (last_cell)
            begin
                free_cnt_reg <= '0;
                unk_cnt_reg  <= '0;
                occ_cnt_reg  <= '0;
                cell_cnt_reg <= '0;
                bad_reg      <= 1'b0;
            end
            else
            begin
                free_cnt_reg <= free_next;
                unk_cnt_reg  <= unk_next;
                occ_cnt_reg  <= occ_next;
                cell_cnt_reg <= cell_next;
                bad_reg      <= bad_next;
            end
        end
    end

    // grid snapshot, unknown-fraction product and verdict
    always_ff @(posedge clk)
    begin
        if (cmd.in_take && last_cell)
        begin
            snap_free_reg <= free_next;
            snap_unk_reg  <= unk_next;
            snap_occ_reg  <= occ_next;
            snap_cell_reg <= cell_next;
            snap_err_reg  <= bad_next || !thr_ok || !ratio_ok;
        end
        if (cmd.mul_load)
            prod_reg <= PROD_W'(maxr_reg) * PROD_W'(snap_cell_reg);
        if (cmd.cmp_load)
        begin
            if (snap_err_reg)
                verd_reg <= VERDICT_ERROR;
            else if (snap_occ_reg != '0)
                verd_reg <= VERDICT_OCCUPIED;
            else if ({PROD_W'(snap_unk_reg), 16'b0} > {16'b0, prod_reg})
                verd_reg <= VERDICT_UNKNOWN;
            else
                verd_reg <= VERDICT_CERTIFIED;
        end
    end

    // shared restoring divider: count * 65536 / cell count, one bit a step
    logic [CNT_W-1:0]   div_cnt;
    logic [CNT_W:0]     div_t, div_diff;
    logic               div_ge;
    logic [RATIO_W-1:0] div_q_next;

    always_comb
    begin
        case (cmd.div_sel)
            SEL_FREE:    div_cnt = snap_free_reg;
            SEL_UNKNOWN: div_cnt = snap_unk_reg;
            SEL_OCC:     div_cnt = snap_occ_reg;
            default:     div_cnt = '0;
        endcase
        div_t      = {div_r_reg, div_b_reg};
        div_diff   = div_t - {1'b0, snap_cell_reg};
        div_ge     = (div_t >= {1'b0, snap_cell_reg});
        div_q_next = {div_q_reg[RATIO_W-2:0], div_ge};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            div_r_reg <= div_cnt >> 1;
            div_b_reg <= div_cnt[0];
            div_q_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_r_reg <= div_ge ? div_diff[CNT_W-1:0] : div_t[CNT_W-1:0];
            div_b_reg <= 1'b0;
            div_q_reg <= div_q_next;
            if (cmd.div_last)
            begin
                case (cmd.div_sel)
                    SEL_FREE:    rat_free_reg <= div_q_next;
                    SEL_UNKNOWN: rat_unk_reg  <= div_q_next;
                    SEL_OCC:     rat_occ_reg  <= div_q_next;
                    default:     ;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            verdict_reg       <= verd_reg;
            free_frac_reg     <= snap_err_reg ? '0 : rat_free_reg;
            unknown_frac_reg  <= snap_err_reg ? '0 : rat_unk_reg;
            occupied_frac_reg <= snap_err_reg ? '0 : rat_occ_reg;
            cell_total_reg    <= RATIO_W'(snap_cell_reg);
        end
    end

    assign verdict       = verdict_reg;
    assign free_frac     = free_frac_reg;
    assign unknown_frac  = unknown_frac_reg;
    assign occupied_frac = occupied_frac_reg;
    assign cell_total    = cell_total_reg;

endmodule

// File: sv/fgc_controller.sv
// ----------------------------------------------------------------------------
// fgc_controller
// Sequencer of the certifier: takes cells, then runs the product, verdict
// and three divisions after the last cell and hands over the result.
// ----------------------------------------------------------------------------
module fgc_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last_cell,
    input  logic              out_ready,
    output logic              in_ready,
    output logic              out_valid,
    output fgc_pkg::fgc_cmd_t cmd
);
    import fgc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_DINIT,
        S_DSTEP,
        S_LOAD
    } state_t;

    localparam logic [DIV_STEP_W-1:0] LAST_STEP = DIV_STEP_W'(DIV_STEPS - 1);

    state_t                state_reg, state_next;
    logic [1:0]            sel_reg, sel_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  take;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        take       = (state_reg == S_IDLE) && in_valid;
        cmd          = '0;
        cmd.in_take  = take;
        cmd.div_sel  = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && last_cell)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_load = 1'b1;
                sel_next     = SEL_FREE;
                state_next   = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    cmd.div_last = 1'b1;
                    if (sel_reg == SEL_OCC)
                        state_next = S_LOAD;
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_DINIT;
                    end
                end
                else
                    step_next = step_reg + DIV_STEP_W'(1);
            end
            S_LOAD:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= SEL_FREE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: sv/freespace_grid_certifier.sv
// ----------------------------------------------------------------------------
// freespace_grid_certifier
// Classifies streamed grid cells as free, occupied or unknown and issues one
// certificate verdict with cell ratios per grid.
// ----------------------------------------------------------------------------
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid/in_ready, free_mass, occ_mass, last_cell | in
//  out     | out_valid/out_ready, verdict, free_frac,        | out
//          | unknown_frac, occupied_frac, cell_total         |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | in
//
//  a cell request is taken in one cycle; the last cell of a grid starts the
//  product, verdict and three 17-step divisions on one shared divider, so
//  in_ready stays low until the result is loaded (later if one waits)
//  the result register lets the next grid stream while a result waits
//  reset clears counters and control; configuration is always ready
// ----------------------------------------------------------------------------
module freespace_grid_certifier #(
    parameter int MAX_CELLS = fgc_pkg::MAX_CELLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fgc_pkg::MASS_W-1:0]    free_mass,
    input  logic [fgc_pkg::MASS_W-1:0]    occ_mass,
    input  logic                          last_cell,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fgc_pkg::VERDICT_W-1:0] verdict,
    output logic [fgc_pkg::RATIO_W-1:0]   free_frac,
    output logic [fgc_pkg::RATIO_W-1:0]   unknown_frac,
    output logic [fgc_pkg::RATIO_W-1:0]   occupied_frac,
    output logic [fgc_pkg::RATIO_W-1:0]   cell_total,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fgc_pkg::MASS_W-1:0]    cfg_data
);
    import fgc_pkg::*;

    fgc_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // sequencer
    fgc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_cell (last_cell),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // counters, divider and result
    fgc_datapath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .free_mass     (free_mass),
        .occ_mass      (occ_mass),
        .last_cell     (last_cell),
        .verdict       (verdict),
        .free_frac     (free_frac),
        .unknown_frac  (unknown_frac),
        .occupied_frac (occupied_frac),
        .cell_total    (cell_total)
    );

`ifndef NO_ASSERTIONS
    // the last cell of a grid makes the block busy
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_cell) |=> !in_ready)
        else $error("cell request taken right after the last cell");

    // a new result is loaded only while cells are held off
    a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result loaded while cells were being taken");

    // error verdict carries zero ratios
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verdict == VERDICT_ERROR) |->
        (free_frac == '0 && unknown_frac == '0 && occupied_frac == '0))
        else $error("error verdict with nonzero ratios");
`endif

endmodule
